// ===== design/assert_macros.svh =====
// Assertion macros shared by the cell voltage statistics RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cvs_pkg.sv =====
// Shared widths, constants and types for the cell voltage statistics block.
// No dependencies; compile first.
package cvs_pkg;

    localparam int BYTE_W            = 8;
    localparam int CELL_W            = 16;
    localparam int CELL_COUNT_W      = 6;
    localparam int MAX_CELLS_DEFAULT = 32;

    localparam logic [CELL_W-1:0] MIN_START = 16'd5000;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SHIFT,
        S_MED_A,
        S_MED_B,
        S_MED_C,
        S_FINISH
    } cvs_state_t;

endpackage

// ===== design/cvs_in_if.sv =====
// Input channel of the cell voltage statistics block: one cell reading.
// Depends on cvs_pkg.
interface cvs_in_if;
    import cvs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] high_byte;
    logic [BYTE_W-1:0] low_byte;
    logic              last_cell;

    modport source (output valid, high_byte, low_byte, last_cell, input ready);
    modport sink   (input valid, high_byte, low_byte, last_cell, output ready);
endinterface

// ===== design/cvs_out_if.sv =====
// Output channel of the cell voltage statistics block: one report summary.
// Depends on cvs_pkg.
interface cvs_out_if;
    import cvs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CELL_COUNT_W-1:0] cell_count;
    logic [CELL_W-1:0]       min_voltage;
    logic [CELL_W-1:0]       max_voltage;
    logic [CELL_W-1:0]       spread_voltage;
    logic [CELL_W-1:0]       avg_voltage;
    logic [CELL_W-1:0]       median_voltage;
    logic                    too_many_cells;

    modport source (output valid, cell_count, min_voltage, max_voltage, spread_voltage,
                    avg_voltage, median_voltage, too_many_cells, input ready);
    modport sink   (input valid, cell_count, min_voltage, max_voltage, spread_voltage,
                    avg_voltage, median_voltage, too_many_cells, output ready);
endinterface

// ===== design/cvs_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module cvs_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/cell_voltage_statistics_core.sv =====
// The first reading of a report, or a dropped one, is done in S_IDLE as it is accepted;
// others walk in S_SHIFT past every kept reading above them (sorted-insert walk).
// Input ready is high only in S_IDLE, so a new reading waits for the one-port store walk.
// When the last cell's walk ends (on acceptance when it needs no walk), the report steps
// through S_MED_A to S_MED_C, then S_FINISH waits for the bit-serial average divider.
// Reset: async, clears control and running statistics; the cell store is left uncleared.
`include "assert_macros.svh"

module cell_voltage_statistics_core #(
    parameter int MAX_CELLS = cvs_pkg::MAX_CELLS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    cvs_in_if.sink           cell_in,
    cvs_out_if.source        stats_out
);
    import cvs_pkg::*;

    // CNT_W holds 0..MAX_CELLS; AW indexes the store; the sum cannot wrap.
    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int AW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SUM_W = CELL_W + CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CELLS);

    // ------------------------------------------------------------------
    // Cell store: kept in ascending order by an insertion walk, so the
    // median is read straight from the middle entries at report end.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] store_mem [MAX_CELLS];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Control and running statistics
    // ------------------------------------------------------------------
    cvs_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cells_seen_reg, cells_seen_next;
    logic [CELL_W-1:0] run_min_reg, run_min_next;
    logic [CELL_W-1:0] run_max_reg, run_max_next;
    logic [SUM_W-1:0]  run_sum_reg, run_sum_next;
    logic              overflow_reg, overflow_next;
    logic              last_reg, last_next;
    logic [CELL_W-1:0] key_reg, key_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CELL_W-1:0] med_lo_reg, med_lo_next;
    logic [CELL_W-1:0] med_reg, med_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [CELL_COUNT_W-1:0] out_count_reg;
    logic [CELL_W-1:0]       out_min_reg;
    logic [CELL_W-1:0]       out_max_reg;
    logic [CELL_W-1:0]       out_spread_reg;
    logic [CELL_W-1:0]       out_avg_reg;
    logic [CELL_W-1:0]       out_med_reg;
    logic                    out_ovf_reg;

    logic              in_fire;
    logic              room;
    logic [CELL_W-1:0] cell_mv;
    logic              result_load;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic              walk_done;

    assign cell_mv = {cell_in.high_byte, cell_in.low_byte};
    assign in_fire = cell_in.valid && cell_in.ready;
    assign room    = cells_seen_reg < MAX_CNT;

    // Average: sum over count, one quotient bit per cycle.
    cvs_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (run_sum_reg),
        .den   (cells_seen_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next      = state_reg;
        cells_seen_next = cells_seen_reg;
        run_min_next    = run_min_reg;
        run_max_next    = run_max_reg;
        run_sum_next    = run_sum_reg;
        overflow_next   = overflow_reg;
        last_next       = last_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        med_lo_next     = med_lo_reg;
        med_next        = med_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = key_reg;
        mem_raddr       = pos_reg - 1'b1;
        div_start       = 1'b0;
        result_load     = 1'b0;
        walk_done       = 1'b0;
        cell_in.ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cell_in.ready = 1'b1;
                if (in_fire)
                begin
                    last_next = cell_in.last_cell;
                    if (room)
                    begin
                        cells_seen_next = cells_seen_reg + 1'b1;
                        run_sum_next    = run_sum_reg + SUM_W'(cell_mv);
                        if (cell_mv > run_max_reg)
                        begin
                            run_max_next = cell_mv;
                        end
                        if (cell_mv < run_min_reg)
                        begin
                            run_min_next = cell_mv;
                        end
                        if (cells_seen_reg == '0)
                        begin
                            // first reading of the report: place it directly
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = cell_mv;
                            state_next = cell_in.last_cell ? S_MED_A : S_IDLE;
                        end
                        else
                        begin
                            // open the walk at the free slot, read its lower neighbor
                            key_next   = cell_mv;
                            pos_next   = AW'(cells_seen_reg);
                            mem_raddr  = AW'(cells_seen_reg - 1'b1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        // store full: drop the reading, flag it
                        overflow_next = 1'b1;
                        state_next    = cell_in.last_cell ? S_MED_A : S_IDLE;
                    end
                end
            end

            S_SHIFT:
            begin
                mem_we = 1'b1;
                if (pos_reg == '0)
                begin
                    mem_wdata = key_reg;
                    walk_done = 1'b1;
                end
                else if (mem_rdata_reg > key_reg)
                begin
                    // move the larger neighbor up, step down one slot
                    mem_wdata = mem_rdata_reg;
                    pos_next  = pos_reg - 1'b1;
                    mem_raddr = pos_reg - AW'(2);
                end
                else
                begin
                    mem_wdata = key_reg;
                    walk_done = 1'b1;
                end
                if (walk_done)
                begin
                    state_next = last_reg ? S_MED_A : S_IDLE;
                end
            end

            S_MED_A:
            begin
                // read the lower middle entry, kick off the average
                mem_raddr  = AW'((cells_seen_reg - 1'b1) >> 1);
                div_start  = 1'b1;
                state_next = S_MED_B;
            end

            S_MED_B:
            begin
                mem_raddr   = AW'(cells_seen_reg >> 1);
                med_lo_next = mem_rdata_reg;
                state_next  = S_MED_C;
            end

            S_MED_C:
            begin
                // odd count reads the same entry twice, so the mean is exact
                med_next   = CELL_W'(({1'b0, med_lo_reg} + {1'b0, mem_rdata_reg}) >> 1);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (div_done && (!out_valid_reg || stats_out.ready))
                begin
                    result_load     = 1'b1;
                    cells_seen_next = '0;
                    run_min_next    = MIN_START;
                    run_max_next    = '0;
                    run_sum_next    = '0;
                    overflow_next   = 1'b0;
                    last_next       = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (stats_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cells_seen_reg <= '0;
            run_min_reg    <= MIN_START;
            run_max_reg    <= '0;
            run_sum_reg    <= '0;
            overflow_reg   <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cells_seen_reg <= cells_seen_next;
            run_min_reg    <= run_min_next;
            run_max_reg    <= run_max_next;
            run_sum_reg    <= run_sum_next;
            overflow_reg   <= overflow_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: hold the walk key and position, the median, the result.
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        med_lo_reg <= med_lo_next;
        med_reg    <= med_next;
        if (result_load)
        begin
            out_count_reg  <= CELL_COUNT_W'(cells_seen_reg);
            out_min_reg    <= run_min_reg;
            out_max_reg    <= run_max_reg;
            out_spread_reg <= run_max_reg - run_min_reg;
            out_ovf_reg    <= overflow_reg;
            // empty report: zeros instead of the quotient and median
            out_avg_reg    <= (cells_seen_reg == '0) ? '0 : CELL_W'(div_quot);
            out_med_reg    <= (cells_seen_reg == '0) ? '0 : med_reg;
        end
    end

    assign stats_out.valid          = out_valid_reg;
    assign stats_out.cell_count     = out_count_reg;
    assign stats_out.min_voltage    = out_min_reg;
    assign stats_out.max_voltage    = out_max_reg;
    assign stats_out.spread_voltage = out_spread_reg;
    assign stats_out.avg_voltage    = out_avg_reg;
    assign stats_out.median_voltage = out_med_reg;
    assign stats_out.too_many_cells = out_ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_cnt_bound, 1'b1, cells_seen_reg <= MAX_CNT, "cell count above store size")
    `ASSERT_IMPL(a_ovf_full, overflow_reg, cells_seen_reg == MAX_CNT,
                 "drop flagged while store has room")
    `ASSERT_IMPL(a_walk_pos, state_reg == S_SHIFT, CNT_W'(pos_reg) < cells_seen_reg,
                 "insertion walk outside kept cells")
    `ASSERT_IMPL(a_load_div, result_load, div_done, "result loaded before average is ready")
    `ASSERT_NEXT(a_cnt_step, in_fire && room,
                 cells_seen_reg == $past(cells_seen_reg) + 1'b1,
                 "kept reading did not advance the count")

endmodule
